// ----- hw/rtl/cap_touch_baseline_detector_top_defines.svh -----
// Assertion macros shared by the touch detector RTL.
// Expects clk and rst to be visible in the module that expands them.
`ifndef CAP_TOUCH_BASELINE_DETECTOR_TOP_DEFINES_SVH
`define CAP_TOUCH_BASELINE_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication
`define CTBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctbd check failed");

// next-cycle implication
`define CTBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctbd check failed");

`endif

// ----- hw/rtl/ctbd_pkg.sv -----
// Types and constants for the capacitive touch baseline detector.
// No dependencies.
package ctbd_pkg;

  localparam int PINS_W  = 12;
  localparam int VAL_W   = 16;
  localparam int CHAN_W  = 4;

  localparam logic [VAL_W-1:0] NO_FLIP = 16'hFFFF;

  // input actions
  localparam logic [1:0] ACT_BEGIN_TOGGLE = 2'd0;
  localparam logic [1:0] ACT_SAMPLE       = 2'd1;
  localparam logic [1:0] ACT_END_TOGGLE   = 2'd2;
  localparam logic [1:0] ACT_END_FRAME    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_HARD_ON = 2'd0;
  localparam logic [1:0] CFG_SOFT_ON = 2'd1;
  localparam logic [1:0] CFG_OFF     = 2'd2;

  localparam logic [VAL_W-1:0] HARD_ON_RESET = 16'd120;
  localparam logic [VAL_W-1:0] SOFT_ON_RESET = 16'd60;
  localparam logic [VAL_W-1:0] OFF_RESET     = 16'd40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_BASE,
    ST_PRESS
  } ctbd_state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [PINS_W-1:0] pins;
    logic              level;
  } ctbd_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  delta;
    logic              pressed;
    logic              last;
  } ctbd_out_t;

  typedef struct packed {
    logic [VAL_W-1:0] hard_on;
    logic [VAL_W-1:0] soft_on;
    logic [VAL_W-1:0] off;
  } ctbd_thr_t;

  // sequencer to datapath
  typedef struct packed {
    ctbd_state_t state;
    logic        step;
  } ctbd_ctl_t;

endpackage

// ----- hw/rtl/ctbd_alu.sv -----
// Shared per-channel arithmetic: frame sum update, baseline tracking and
// press decision, all through one 16-bit adder. Depends on ctbd_pkg.
module ctbd_alu #(
  parameter int BASE_SCALE = 1024,
  localparam int RW = $clog2(BASE_SCALE)
) (
  input  ctbd_pkg::ctbd_state_t      mode,
  input  ctbd_pkg::ctbd_thr_t        thr,
  input  logic [ctbd_pkg::VAL_W-1:0] sum,
  input  logic [ctbd_pkg::VAL_W-1:0] flip,
  input  logic                       base_valid,
  input  logic [ctbd_pkg::VAL_W-1:0] base_q,
  input  logic [RW-1:0]              base_r,
  input  logic [ctbd_pkg::VAL_W-1:0] cur,
  input  logic [ctbd_pkg::VAL_W-1:0] prv,
  input  logic [ctbd_pkg::VAL_W-1:0] nxt,
  input  logic                       has_prv,
  input  logic                       has_nxt,
  input  logic                       soft_ok,
  input  logic                       btn,
  output logic [ctbd_pkg::VAL_W-1:0] sum_new,
  output logic [ctbd_pkg::VAL_W-1:0] q_new,
  output logic [RW-1:0]              r_new,
  output logic [ctbd_pkg::VAL_W-1:0] delta_new,
  output logic                       btn_new
);

  logic [ctbd_pkg::VAL_W-1:0] add_a;
  logic [ctbd_pkg::VAL_W-1:0] add_b;
  logic [ctbd_pkg::VAL_W:0]   add_y;
  logic [RW:0]                r_inc;
  logic                       r_wrap;
  logic [RW-1:0]              r1;
  logic                       over;
  logic [ctbd_pkg::VAL_W-1:0] near;
  logic                       turn_on;

  // baseline kept as quotient and remainder of BASE_SCALE
  assign r_inc  = {1'b0, base_r} + (RW+1)'(1);
  assign r_wrap = (r_inc == (RW+1)'(BASE_SCALE));
  assign r1     = r_wrap ? '0 : r_inc[RW-1:0];

  always_comb begin
    near = '0;
    if (has_prv) begin
      near = prv;
    end
    if (has_nxt && (near < nxt)) begin
      near = nxt;
    end
  end

  always_comb begin
    unique case (mode)
      ctbd_pkg::ST_SUM: begin
        add_a = sum;
        add_b = flip;
      end
      ctbd_pkg::ST_BASE: begin
        add_a = base_q;
        add_b = ctbd_pkg::VAL_W'(r_wrap);
      end
      ctbd_pkg::ST_PRESS: begin
        add_a = near;
        add_b = thr.soft_on;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_y = {1'b0, add_a} + {1'b0, add_b};

  assign sum_new = ((sum == ctbd_pkg::NO_FLIP) || (flip == ctbd_pkg::NO_FLIP)) ?
                   ctbd_pkg::NO_FLIP : add_y[ctbd_pkg::VAL_W-1:0];

  assign over = (add_y > {1'b0, sum}) || ((add_y == {1'b0, sum}) && (r1 != '0));

  always_comb begin
    if (!base_valid || over) begin
      q_new = sum;
      r_new = '0;
    end else begin
      q_new = add_y[ctbd_pkg::VAL_W-1:0];
      r_new = r1;
    end
  end

  assign delta_new = sum - q_new;

  // neighbour sum compared without wrap
  assign turn_on = (cur > thr.hard_on) ||
                   (soft_ok && (cur > thr.soft_on) && ({1'b0, cur} > add_y));
  assign btn_new = btn ? !(cur < thr.off) : turn_on;

endmodule

// ----- hw/rtl/ctbd_ctrl.sv -----
// Sequencer: walks the channel counter for the end-toggle and end-frame
// passes. Depends on ctbd_pkg.
`include "cap_touch_baseline_detector_top_defines.svh"
module ctbd_ctrl #(
  parameter int CHANNELS = 12,
  localparam int CW = $clog2(CHANNELS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [1:0]          action,
  input  logic                out_free,
  output ctbd_pkg::ctbd_ctl_t ctl,
  output logic [CW-1:0]       cnt
);

  localparam logic [CW-1:0] LAST = CW'(CHANNELS - 1);

  ctbd_pkg::ctbd_state_t state;
  ctbd_pkg::ctbd_state_t state_next;
  logic [CW-1:0]         cnt_next;
  logic                  step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctbd_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    step       = 1'b0;
    unique case (state)
      ctbd_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (in_fire && (action == ctbd_pkg::ACT_END_TOGGLE)) begin
          state_next = ctbd_pkg::ST_SUM;
        end else if (in_fire && (action == ctbd_pkg::ACT_END_FRAME)) begin
          state_next = ctbd_pkg::ST_BASE;
        end
      end
      ctbd_pkg::ST_SUM: begin
        step = 1'b1;
        if (cnt == LAST) begin
          state_next = ctbd_pkg::ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      ctbd_pkg::ST_BASE: begin
        step = 1'b1;
        if (cnt == LAST) begin
          state_next = ctbd_pkg::ST_PRESS;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      ctbd_pkg::ST_PRESS: begin
        step = out_free;
        if (out_free) begin
          if (cnt == LAST) begin
            state_next = ctbd_pkg::ST_IDLE;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + CW'(1);
          end
        end
      end
      default: begin
        state_next = ctbd_pkg::ST_IDLE;
      end
    endcase
  end

  assign ctl.state = state;
  assign ctl.step  = step;

  `CTBD_ASSERT_NEXT(a_frame_start, in_fire && (action == ctbd_pkg::ACT_END_FRAME), state == ctbd_pkg::ST_BASE && cnt == '0)
  `CTBD_ASSERT_NEXT(a_press_hold, state == ctbd_pkg::ST_PRESS && !out_free, $stable(cnt) && state == ctbd_pkg::ST_PRESS)
  `CTBD_ASSERT_NEXT(a_press_done, state == ctbd_pkg::ST_PRESS && out_free && cnt == LAST, state == ctbd_pkg::ST_IDLE)

endmodule

// ----- hw/rtl/cap_touch_baseline_detector_top.sv -----
// Top level of the capacitive touch baseline detector.
// Depends on ctbd_pkg, ctbd_ctrl, ctbd_alu and the defines header.
//
// Capacitive touch front end for CHANNELS electrodes. A begin-toggle transfer
// sets the drive level, presets the pin latch to the opposite level and marks
// every channel as not yet flipped. Pin-sample transfers OR (rising) or AND
// (falling) into the latch and record the sample index at which each channel
// first flipped; samples past SAMPLES are dropped. An end toggle folds the
// flip times into 16-bit per-channel sums (a channel that never flipped pins
// its sum at 0xFFFF). An end frame tracks a slowly rising baseline held at
// BASE_SCALE times the sum, forms deltas, updates the pressed flags and emits
// one result transfer per channel, channel 0 first, last set on the final one.
// Flow control: begin-toggle and pin-sample transfers leave input ready, so
// samples can stream back to back. An end toggle holds off input while its
// sum pass walks the channels, one channel per cycle through the shared
// adder. An end frame holds off input for two passes over the channels, one
// for baseline and delta and one for the press decision that loads one
// result per cycle into the output register while output is not stalled.
// Output backpressure stretches only the second pass. The last result may
// still wait in the output register while new input is taken. No clearing
// pass is needed after reset. Thresholds are written through the config
// channel (index 0 hard on, 1 soft on, 2 off); writes to others are dropped.
`include "cap_touch_baseline_detector_top_defines.svh"
module cap_touch_baseline_detector_top #(
  parameter int CHANNELS   = 12,
  parameter int SAMPLES    = 100,
  parameter int BASE_SCALE = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ctbd_pkg::ctbd_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ctbd_pkg::ctbd_out_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [ctbd_pkg::VAL_W-1:0] cfg_data
);

  localparam int CW         = $clog2(CHANNELS);
  localparam int SW         = $clog2(SAMPLES + 1);
  localparam int RW         = $clog2(BASE_SCALE);
  localparam int SOFT_COUNT = CHANNELS - 2;
  localparam int VW         = ctbd_pkg::VAL_W;

  // configuration
  ctbd_pkg::ctbd_thr_t thr;

  // toggle state
  logic [CHANNELS-1:0] latched_pins;
  logic                drive_level;
  logic [SW-1:0]       sample_index;
  logic [VW-1:0]       flip_time [CHANNELS];
  logic [VW-1:0]       frame_sum [CHANNELS];

  // baseline = base_q * BASE_SCALE + base_r; no reset, written on first frame
  logic [VW-1:0]       base_q [CHANNELS];
  logic [RW-1:0]       base_r [CHANNELS];
  logic                baseline_valid;
  logic [CHANNELS-1:0] button_on;

  // deltas shift in during the baseline pass, shift out during the press pass
  logic [VW-1:0]       delta_line [CHANNELS];
  logic [VW-1:0]       prv_delta;

  ctbd_pkg::ctbd_ctl_t ctl;
  logic [CW-1:0]       cnt;
  logic                in_fire;
  logic                out_free;

  logic [CHANNELS+ctbd_pkg::PINS_W-1:0] pins_wide;
  logic [CHANNELS-1:0] pins_ch;
  logic [CHANNELS-1:0] cur_pins;
  logic [CHANNELS-1:0] diff_pins;

  logic [VW-1:0] sum_new;
  logic [VW-1:0] q_new;
  logic [RW-1:0] r_new;
  logic [VW-1:0] delta_new;
  logic          btn_new;
  logic          has_prv;
  logic          has_nxt;
  logic          soft_ok;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  ctbd_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .action  (in_data.action),
    .out_free(out_free),
    .ctl     (ctl),
    .cnt     (cnt)
  );

  assign in_ready = (ctl.state == ctbd_pkg::ST_IDLE);

  // channels past the pin field see zero
  assign pins_wide = {CHANNELS'(0), in_data.pins};
  assign pins_ch   = pins_wide[CHANNELS-1:0];
  assign cur_pins  = drive_level ? (latched_pins | pins_ch) : (latched_pins & pins_ch);
  assign diff_pins = cur_pins ^ latched_pins;

  // neighbour window flags for the soft turn-on group
  assign has_prv = (cnt != '0);
  assign soft_ok = (32'(cnt) < SOFT_COUNT);
  assign has_nxt = ((32'(cnt) + 32'd1) < SOFT_COUNT);

  ctbd_alu #(
    .BASE_SCALE(BASE_SCALE)
  ) u_alu (
    .mode      (ctl.state),
    .thr       (thr),
    .sum       (frame_sum[cnt]),
    .flip      (flip_time[cnt]),
    .base_valid(baseline_valid),
    .base_q    (base_q[cnt]),
    .base_r    (base_r[cnt]),
    .cur       (delta_line[0]),
    .prv       (prv_delta),
    .nxt       (delta_line[1]),
    .has_prv   (has_prv),
    .has_nxt   (has_nxt),
    .soft_ok   (soft_ok),
    .btn       (button_on[cnt]),
    .sum_new   (sum_new),
    .q_new     (q_new),
    .r_new     (r_new),
    .delta_new (delta_new),
    .btn_new   (btn_new)
  );

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.hard_on <= ctbd_pkg::HARD_ON_RESET;
      thr.soft_on <= ctbd_pkg::SOFT_ON_RESET;
      thr.off     <= ctbd_pkg::OFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ctbd_pkg::CFG_HARD_ON: thr.hard_on <= cfg_data;
        ctbd_pkg::CFG_SOFT_ON: thr.soft_on <= cfg_data;
        ctbd_pkg::CFG_OFF:     thr.off     <= cfg_data;
        default: ;
      endcase
    end
  end

  // latch, sample index and flip times
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_pins <= '0;
      drive_level  <= 1'b0;
      sample_index <= '0;
      for (int j = 0; j < CHANNELS; j++) begin
        flip_time[j] <= ctbd_pkg::NO_FLIP;
      end
    end else if (in_fire) begin
      unique case (in_data.action)
        ctbd_pkg::ACT_BEGIN_TOGGLE: begin
          drive_level  <= in_data.level;
          latched_pins <= in_data.level ? '0 : '1;
          sample_index <= '0;
          for (int j = 0; j < CHANNELS; j++) begin
            flip_time[j] <= ctbd_pkg::NO_FLIP;
          end
        end
        ctbd_pkg::ACT_SAMPLE: begin
          if (sample_index < SW'(SAMPLES)) begin
            latched_pins <= cur_pins;
            sample_index <= sample_index + SW'(1);
            for (int j = 0; j < CHANNELS; j++) begin
              if (diff_pins[j]) begin
                flip_time[j] <= VW'(sample_index);
              end
            end
          end
        end
        ctbd_pkg::ACT_END_TOGGLE: sample_index <= SW'(SAMPLES);
        default: ;
      endcase
    end
  end

  // frame sums, baseline valid and button flags
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_valid <= 1'b0;
      button_on      <= '0;
      for (int j = 0; j < CHANNELS; j++) begin
        frame_sum[j] <= '0;
      end
    end else if (ctl.step) begin
      unique case (ctl.state)
        ctbd_pkg::ST_SUM: frame_sum[cnt] <= sum_new;
        ctbd_pkg::ST_BASE: begin
          frame_sum[cnt] <= '0;
          if (cnt == CW'(CHANNELS - 1)) begin
            baseline_valid <= 1'b1;
          end
        end
        ctbd_pkg::ST_PRESS: button_on[cnt] <= btn_new;
        default: ;
      endcase
    end
  end

  // baseline store and delta line
  always_ff @(posedge clk) begin
    if (ctl.step && (ctl.state == ctbd_pkg::ST_BASE)) begin
      base_q[cnt] <= q_new;
      base_r[cnt] <= r_new;
      delta_line[CHANNELS-1] <= delta_new;
    end
    if (ctl.step && ((ctl.state == ctbd_pkg::ST_BASE) ||
                     (ctl.state == ctbd_pkg::ST_PRESS))) begin
      for (int j = 0; j < CHANNELS - 1; j++) begin
        delta_line[j] <= delta_line[j+1];
      end
      prv_delta <= delta_line[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.step && (ctl.state == ctbd_pkg::ST_PRESS)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && (ctl.state == ctbd_pkg::ST_PRESS)) begin
      out_data.channel <= ctbd_pkg::CHAN_W'(cnt);
      out_data.delta   <= delta_line[0];
      out_data.pressed <= btn_new;
      out_data.last    <= (cnt == CW'(CHANNELS - 1));
    end
  end

  `CTBD_ASSERT_NOW(a_sample_bound, 1'b1, sample_index <= SW'(SAMPLES))
  `CTBD_ASSERT_NEXT(a_result_loaded, ctl.step && ctl.state == ctbd_pkg::ST_PRESS, out_valid && out_data.channel == ctbd_pkg::CHAN_W'($past(cnt)))
  `CTBD_ASSERT_NEXT(a_base_marked, ctl.step && ctl.state == ctbd_pkg::ST_BASE && cnt == CW'(CHANNELS - 1), baseline_valid)

endmodule
